>>> design/assert_macros.svh
// Assertion macros used by indexed_list_store.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Trigger in this cycle implies consequence in the next one.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/ils_pkg.sv
// Package for the indexed list store: operation codes, status codes,
// cell command type and the read-miss constant. No dependencies.
package ils_pkg;

  localparam logic [2:0] MODE_READ     = 3'd0;
  localparam logic [2:0] MODE_INS_HEAD = 3'd1;
  localparam logic [2:0] MODE_INS_TAIL = 3'd2;
  localparam logic [2:0] MODE_INS_POS  = 3'd3;
  localparam logic [2:0] MODE_DELETE   = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [31:0] READ_MISS = -32'sd1;

  // Broadcast command to every cell of the row.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE
  } cell_cmd_t;

endpackage

>>> design/ils_if.sv
// Valid/ready channel interfaces for the operation and result beats.
// Depends on nothing; used by the top level.
interface ils_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [6:0]         position;
  logic signed [31:0] new_value;

  modport source (output valid, mode, position, new_value, input ready);
  modport sink   (input valid, mode, position, new_value, output ready);
endinterface

interface ils_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  logic [6:0]         length;

  modport source (output valid, read_value, status, length, input ready);
  modport sink   (input valid, read_value, status, length, output ready);
endinterface

>>> design/ils_cell.sv
// One storage cell of the list row: holds, loads, or takes a neighbor's value.
// Depends on ils_pkg (cell_cmd_t).
module ils_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 6
) (
  input  logic                clk,
  input  ils_pkg::cell_cmd_t  cmd,
  input  logic [IDX_W-1:0]    slot,
  input  logic signed [31:0]  new_value,
  input  logic signed [31:0]  left_val,
  input  logic signed [31:0]  right_val,
  output logic signed [31:0]  val
);
  import ils_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [31:0] val_r, val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (cmd)
      CMD_INSERT: begin
        if (MY_IDX == slot) val_nxt = new_value;
        else if (MY_IDX > slot) val_nxt = left_val;   // shift toward tail
      end
      CMD_DELETE: begin
        if (MY_IDX >= slot) val_nxt = right_val;      // close the gap
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
endmodule

>>> design/indexed_list_store.sv
// indexed_list_store: an ordered list of up to CAPACITY signed 32-bit values,
// one operation per input beat (read, insert at head, at tail or before a
// position, delete at a position), one result beat per operation carrying the
// read value, a status code and the new length. Each operation completes as
// it is taken, so the block takes one beat per clock: the values live in a row
// of CAPACITY cells that all hold, load or take their neighbor's value in the
// same cycle, and a read is an AND-OR select across the row. The result sits
// in an output register, so a new beat is taken whenever that register is
// empty or being drained in the same cycle. After reset the list is empty;
// no clearing pass is needed, since only slots below the length are read.
// Depends on ils_pkg, ils_if.sv, ils_cell and assert_macros.svh.
`include "assert_macros.svh"

module indexed_list_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ils_in_if.sink     in_ch,
  ils_out_if.source  out_ch
);
  import ils_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // compare width covers both the 7-bit position and the count
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  // element count and output register
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  logic signed [31:0] read_value_r, read_value_nxt;
  logic [1:0]         status_r, status_nxt;

  logic               in_acc;
  logic [CMP_W-1:0]   pos_c, cnt_c;
  logic               try_ins;
  logic [IDX_W-1:0]   slot;
  cell_cmd_t          cmd;
  logic               del_ok;
  logic signed [31:0] sel_val;
  logic signed [31:0] cell_val [CAPACITY];

  // a beat goes in when the result register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign pos_c = CMP_W'(in_ch.position);
  assign cnt_c = CMP_W'(count_r);

  // read select: each cell gated by its own index match
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMP_W'(i) == pos_c) sel_val = sel_val | cell_val[i];
    end
  end

  // operation decode
  always_comb begin
    read_value_nxt = READ_MISS;
    status_nxt     = ST_DONE;
    try_ins        = 1'b0;
    del_ok         = 1'b0;
    slot           = '0;
    case (in_ch.mode)
      MODE_READ: begin
        if (pos_c < cnt_c) read_value_nxt = sel_val;
      end
      MODE_INS_HEAD: begin
        try_ins = 1'b1;
      end
      MODE_INS_TAIL: begin
        try_ins = 1'b1;
        slot    = IDX_W'(count_r);
      end
      MODE_INS_POS: begin
        if (pos_c > cnt_c) begin
          status_nxt = ST_RANGE;
        end else begin
          try_ins = 1'b1;
          slot    = IDX_W'(in_ch.position);
        end
      end
      MODE_DELETE: begin
        if (pos_c >= cnt_c) begin
          status_nxt = ST_RANGE;
        end else begin
          del_ok = 1'b1;
          slot   = IDX_W'(in_ch.position);
        end
      end
      default: status_nxt = ST_RANGE;
    endcase
    // full check comes after the range check
    if (try_ins && count_r == FULL_CNT) begin
      status_nxt = ST_FULL;
      try_ins    = 1'b0;
    end
  end

  always_comb begin
    cmd       = CMD_HOLD;
    count_nxt = count_r;
    if (in_acc) begin
      if (try_ins) begin
        cmd       = CMD_INSERT;
        count_nxt = count_r + CNT_W'(1);
      end else if (del_ok) begin
        cmd       = CMD_DELETE;
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // the cell row; ends see the new value and their own value
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_in, right_in;
    if (g == 0) begin : g_head
      assign left_in = in_ch.new_value;
    end else begin : g_mid_l
      assign left_in = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_in = cell_val[g];
    end else begin : g_mid_r
      assign right_in = cell_val[g+1];
    end
    ils_cell #(
      .IDX   (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .slot      (slot),
      .new_value (in_ch.new_value),
      .left_val  (left_in),
      .right_val (right_in),
      .val       (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
    if (in_acc) begin
      read_value_r <= read_value_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = read_value_r;
  assign out_ch.status     = status_r;
  assign out_ch.length     = 7'(count_r);

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= FULL_CNT)
  `ASSERT_ALWAYS(a_full_means_full, clk, rst_n,
    !(out_valid_r && status_r == ST_FULL) || count_r == FULL_CNT)
  `ASSERT_NEXT(a_delete_shrinks, clk, rst_n, in_acc && del_ok,
    count_r == $past(count_r) - CNT_W'(1))
  `ASSERT_NEXT(a_insert_grows, clk, rst_n, in_acc && try_ins,
    count_r == $past(count_r) + CNT_W'(1))

endmodule

>>> test/ils_result_checker.sv
// Result checker for the indexed list store: keeps a shadow copy of the list,
// predicts the result of every accepted operation beat and compares it with the
// result beats. Depends on ils_pkg and the channel interfaces in ils_if.sv.
`timescale 1ns / 100ps

module ils_result_checker #(
  parameter int LIST_CAP = 64
) (
  input  logic clk,
  input  logic rst_n,
  ils_in_if    op_mon,
  ils_out_if   res_mon,
  output int   err_count,
  output int   pending,
  output int   stored_count
);
  import ils_pkg::*;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         length;
  } list_result_t;

  logic signed [31:0] shadow_list [LIST_CAP];
  int                 shadow_len = 0;
  int                 fail_cnt = 0;
  list_result_t       expected_results [$];

  // Opens a gap at slot and writes v there; caller has checked slot <= length.
  function automatic logic [1:0] place_value(int slot, logic signed [31:0] v);
    if (shadow_len >= LIST_CAP) return ST_FULL;
    for (int i = shadow_len; i > slot; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[slot] = v;
    shadow_len++;
    return ST_DONE;
  endfunction

  function automatic list_result_t apply_list_op(logic [2:0] op, logic [6:0] pos,
                                                 logic signed [31:0] v);
    list_result_t r;
    r.read_value = READ_MISS;
    r.status     = ST_DONE;
    case (op)
      MODE_READ: begin
        if (pos < shadow_len) r.read_value = shadow_list[pos];
      end
      MODE_INS_HEAD: r.status = place_value(0, v);
      MODE_INS_TAIL: r.status = place_value(shadow_len, v);
      MODE_INS_POS: begin
        // range check wins over the full check
        if (pos > shadow_len) r.status = ST_RANGE;
        else r.status = place_value(pos, v);
      end
      MODE_DELETE: begin
        if (pos >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = pos; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.length = 7'(shadow_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got = '{read_value: res_mon.read_value, status: res_mon.status,
                length: res_mon.length};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat: read_value %0d status %0d length %0d",
                   $time, got.read_value, got.status, got.length);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (got.read_value !== want.read_value || got.status !== want.status ||
              got.length !== want.length) begin
            $display("%0t: expected read_value %0d status %0d length %0d, got %0d %0d %0d",
                     $time, want.read_value, want.status, want.length,
                     got.read_value, got.status, got.length);
            fail_cnt++;
          end
        end
      end
      if (op_mon.valid && op_mon.ready)
        expected_results.push_back(apply_list_op(op_mon.mode, op_mon.position,
                                                 op_mon.new_value));
    end
    err_count    <= fail_cnt;
    pending      <= expected_results.size();
    stored_count <= shadow_len;
  end

endmodule

>>> test/tb_indexed_list_store.sv
// Top of the indexed list store testbench: clock, reset, operation stimulus,
// result-side backpressure, watchdog and verdict. Depends on ils_pkg, ils_if.sv,
// the block itself and ils_result_checker.
`timescale 1ns / 100ps

module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int LIST_CAP     = 64;
  localparam int RANDOM_ITEMS = 425;
  localparam int QUIET_TAIL   = 60;    // last random beats run with no idling
  localparam int STALL_LIMIT  = 200;   // cycles with no beat on either side
  localparam int DRAIN_LIMIT  = 500;

  // modes the block does not know; they must come back flagged out of range
  localparam logic [2:0] MODE_BAD_LO = 3'd5;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;

  typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIXED} mix_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic quiet = 1'b0;   // set: neither side idles
  int   err_count;
  int   pending;
  int   stored_count;
  int   stall_cycles = 0;

  ils_in_if  op_ch ();
  ils_out_if res_ch ();

  always #5 clk = ~clk;

  indexed_list_store #(.CAPACITY(LIST_CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (op_ch),
    .out_ch (res_ch)
  );

  ils_result_checker #(.LIST_CAP(LIST_CAP)) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_mon       (op_ch),
    .res_mon      (res_ch),
    .err_count    (err_count),
    .pending      (pending),
    .stored_count (stored_count)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Drives one operation beat. Called at a falling edge, returns at the falling
  // edge after the beat was taken. Valid stays high on return so back-to-back
  // beats never lower and raise it in the same step; a gap lowers it first.
  task automatic send_op(input logic [2:0] m, input logic [6:0] p,
                         input logic signed [31:0] v);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op_ch.valid     <= 1'b1;
    op_ch.mode      <= m;
    op_ch.position  <= p;
    op_ch.new_value <= v;
    do @(posedge clk); while (!op_ch.ready);
    @(negedge clk);
  endtask

  // Values lean on the sign extremes, -1 (same as a read miss) and zero.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions inside the list, often exactly at the length (tail
  // insert, read miss, delete out of range), sometimes anywhere up to capacity.
  function automatic logic [6:0] pick_pos(int len);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return (len == 0) ? 7'd0 : 7'($urandom_range(0, len - 1));
    if (r < 8) return 7'(len);
    return 7'($urandom_range(0, LIST_CAP));
  endfunction

  // Grow phases push the list to full so dropped inserts show up; shrink
  // phases drain it back toward empty; mixed phases are read heavy and carry
  // the unknown modes.
  function automatic logic [2:0] pick_mode(mix_t ph);
    int r;
    r = $urandom_range(0, 19);
    case (ph)
      PH_GROW: begin
        if (r < 6)  return MODE_INS_HEAD;
        if (r < 10) return MODE_INS_TAIL;
        if (r < 15) return MODE_INS_POS;
        if (r < 17) return MODE_READ;
        return MODE_DELETE;
      end
      PH_SHRINK: begin
        if (r < 12) return MODE_DELETE;
        if (r < 15) return MODE_READ;
        if (r < 17) return MODE_INS_POS;
        if (r < 19) return MODE_INS_HEAD;
        return MODE_INS_TAIL;
      end
      default: begin
        if (r < 8)  return MODE_READ;
        if (r < 10) return MODE_INS_HEAD;
        if (r < 12) return MODE_INS_TAIL;
        if (r < 14) return MODE_INS_POS;
        if (r < 19) return MODE_DELETE;
        return 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Operation side
  // --------------------------------------------------------------------------
  initial begin
    mix_t phase;
    int   phase_end;
    int   wait_cnt;

    op_ch.valid     <= 1'b0;
    op_ch.mode      <= MODE_READ;
    op_ch.position  <= '0;
    op_ch.new_value <= '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list corner cases first.
    send_op(MODE_READ, 7'd0, 32'sd0);              // read on empty list misses
    send_op(MODE_DELETE, 7'd0, 32'sd0);            // delete on empty is out of range
    send_op(MODE_INS_POS, 7'd1, 32'sd5);           // insert past length ignored
    send_op(MODE_INS_POS, 7'd0, 32'sh7fffffff);    // position 0 into empty list
    send_op(MODE_INS_HEAD, 7'd0, 32'sh80000000);
    send_op(MODE_INS_TAIL, 7'd0, -32'sd1);
    send_op(MODE_INS_POS, 7'd3, 32'sd0);           // position == length appends
    send_op(MODE_INS_POS, 7'd2, 32'sh5a5a5a5a);    // middle insert shifts the rest
    send_op(MODE_INS_POS, 7'd6, 32'sd1);           // one past length, ignored
    for (int i = 0; i < 5; i++) send_op(MODE_READ, 7'(i), 32'sd0);
    send_op(MODE_READ, 7'd5, 32'sd0);              // read at length misses
    send_op(MODE_READ, 7'd64, 32'sd0);             // top position bit set
    send_op(MODE_DELETE, 7'd5, 32'sd0);            // delete at length, ignored
    send_op(MODE_DELETE, 7'd2, 32'sd0);            // middle
    send_op(MODE_DELETE, 7'd3, 32'sd0);            // last
    send_op(MODE_DELETE, 7'd0, 32'sd0);            // head
    for (int m = MODE_BAD_LO; m <= MODE_BAD_HI; m++)
      send_op(3'(m), 7'd0, 32'sd3);
    send_op(MODE_READ, 7'd0, 32'sd0);

    // Random: a long grow phase first so the full case is reached early,
    // then a shrink phase, then phases of random kind.
    phase     = PH_GROW;
    phase_end = 120;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == phase_end) begin
        phase     = (phase == PH_GROW) ? PH_SHRINK : mix_t'($urandom_range(0, 2));
        phase_end = n + $urandom_range(30, 90);
        quiet     = ($urandom_range(0, 3) == 0);
      end
      if (n >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      send_op(pick_mode(phase), pick_pos(stored_count), pick_value());
    end
    op_ch.valid <= 1'b0;

    // Drain: every expected result must arrive; a further wait follows so a
    // stray extra beat would still be caught.
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (pending != 0) begin
      $display("TB_ERROR");
    end else begin
      repeat (5) @(posedge clk);
      if (err_count == 0) begin
        $display("TB_OK");
      end else begin
        $display("TB_ERROR");
      end
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: ready high for a random stretch, then a stall burst unless
  // the run is in a quiet stretch.
  // --------------------------------------------------------------------------
  initial begin
    res_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      if (!quiet) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no beat on either channel means a hang.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
